>>> hdl/sbpa_pkg.sv
// Package for the stem band power analyzer: controller states, datapath
// command and status types, configuration type and register index codes.
// No dependencies.
package sbpa_pkg;

    localparam int NUM_BANDS  = 9;
    localparam int DIV_STEPS  = 48;
    localparam int LAST_STEM  = 2;
    localparam int LAST_FILT  = 3;
    localparam int MID_FILT   = 2;
    localparam int HP_FILT    = 1;

    localparam logic [2:0] REG_LOW_LP   = 3'd0;
    localparam logic [2:0] REG_LOW_HP   = 3'd1;
    localparam logic [2:0] REG_HIGH_LP  = 3'd2;
    localparam logic [2:0] REG_HIGH_HP  = 3'd3;
    localparam logic [2:0] REG_SPC      = 3'd4;
    localparam logic [2:0] REG_HGAIN    = 3'd5;
    localparam logic [2:0] REG_VGAIN    = 3'd6;
    localparam logic [2:0] REG_LIMIT    = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MIX,
        ST_HARM,
        ST_VOC,
        ST_DRUMS,
        ST_B0,
        ST_B1,
        ST_A1,
        ST_A2,
        ST_YY,
        ST_EN,
        ST_CLOSE,
        ST_WAIT_OUT,
        ST_DLOAD,
        ST_DSTEP,
        ST_DSTORE,
        ST_PUBLISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MIX,
        OP_HARM,
        OP_VOC,
        OP_DRUMS,
        OP_B0,
        OP_B1,
        OP_A1,
        OP_A2,
        OP_YY,
        OP_EN,
        OP_CLOSE,
        OP_DLOAD,
        OP_DSTEP,
        OP_DSTORE
    } op_t;

    // Publishing has no op code of its own; it is signalled through a separate flag.
    typedef struct packed {
        op_t        op;
        logic       publish;
        logic [1:0] stem;
        logic [1:0] filt;
        logic [3:0] band;
    } dp_cmd_t;

    typedef struct packed {
        logic close;
        logic emit;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [3:0][63:0] coefs;
        logic [15:0]      spc;
        logic [15:0]      hgain;
        logic [15:0]      vgain;
        logic [19:0]      limit;
    } cfg_t;

endpackage

>>> hdl/stem_band_power_analyzer.sv
// Top level of the stem band power analyzer: configuration registers,
// controller and datapath.
// Depends on sbpa_pkg, sbpa_ctrl and sbpa_dp.
//
//  Channel   Handshake          Payload
//  input     s_valid/s_ready    mix, harmonics and vocals stereo samples, stems_present
//  result    m_valid/m_ready    column index and nine band mean squares
//  config    cfg_wen            cfg_addr, cfg_wdata (no wait, no read-back)
//
// One multiplier is shared by the mixing stage and twelve biquads of six steps each.
// A frame that closes a column adds nine 48-step restoring divisions. Control, filter,
// accumulator and column state reset; input latches and arithmetic registers do not.
// A new frame is accepted while a finished column beat waits; the next column's
// division, and the input with it, stalls until the result register is taken.
module stem_band_power_analyzer
    import sbpa_pkg::*;
#(
    parameter int COLUMN_BITS = 20,
    parameter int COEF_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [2:0]             cfg_addr,
    input  logic [63:0]            cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [15:0]     s_mix_left,
    input  logic signed [15:0]     s_mix_right,
    input  logic signed [15:0]     s_harm_left,
    input  logic signed [15:0]     s_harm_right,
    input  logic signed [15:0]     s_voc_left,
    input  logic signed [15:0]     s_voc_right,
    input  logic                   s_stems_present,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COLUMN_BITS-1:0] m_column,
    output logic [31:0]            m_drums_low,
    output logic [31:0]            m_drums_mid,
    output logic [31:0]            m_drums_high,
    output logic [31:0]            m_harm_low,
    output logic [31:0]            m_harm_mid,
    output logic [31:0]            m_harm_high,
    output logic [31:0]            m_voc_low,
    output logic [31:0]            m_voc_mid,
    output logic [31:0]            m_voc_high
);

    localparam logic [19:0] LIMIT_RST = (COLUMN_BITS >= 20) ? 20'hFFFFF :
                                        20'((64'd1 << COLUMN_BITS) - 64'd1);

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coefs <= '0;
            cfg_reg.spc   <= 16'd480;
            cfg_reg.hgain <= 16'd16384;
            cfg_reg.vgain <= 16'd16384;
            cfg_reg.limit <= LIMIT_RST;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_LOW_LP:  cfg_reg.coefs[0] <= cfg_wdata;
                REG_LOW_HP:  cfg_reg.coefs[1] <= cfg_wdata;
                REG_HIGH_LP: cfg_reg.coefs[2] <= cfg_wdata;
                REG_HIGH_HP: cfg_reg.coefs[3] <= cfg_wdata;
                REG_SPC:     cfg_reg.spc      <= cfg_wdata[15:0];
                REG_HGAIN:   cfg_reg.hgain    <= cfg_wdata[15:0];
                REG_VGAIN:   cfg_reg.vgain    <= cfg_wdata[15:0];
                REG_LIMIT:   cfg_reg.limit    <= cfg_wdata[19:0];
                default: ;
            endcase
        end
    end

    sbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sbpa_dp #(
        .COLUMN_BITS (COLUMN_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .stat            (stat),
        .s_mix_left      (s_mix_left),
        .s_mix_right     (s_mix_right),
        .s_harm_left     (s_harm_left),
        .s_harm_right    (s_harm_right),
        .s_voc_left      (s_voc_left),
        .s_voc_right     (s_voc_right),
        .s_stems_present (s_stems_present),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_column        (m_column),
        .m_drums_low     (m_drums_low),
        .m_drums_mid     (m_drums_mid),
        .m_drums_high    (m_drums_high),
        .m_harm_low      (m_harm_low),
        .m_harm_mid      (m_harm_mid),
        .m_harm_high     (m_harm_high),
        .m_voc_low       (m_voc_low),
        .m_voc_mid       (m_voc_mid),
        .m_voc_high      (m_voc_high)
    );

endmodule

>>> hdl/sbpa_ctrl.sv
// Controller of the stem band power analyzer: sequences the shared multiplier
// through mixing and twelve biquads, then runs the column divider.
// Depends on sbpa_pkg.
module sbpa_ctrl
    import sbpa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [1:0] stem_reg, stem_next;
    logic [1:0] filt_reg, filt_next;
    logic [3:0] dband_reg, dband_next;
    logic [5:0] dstep_reg, dstep_next;
    logic [1:0] band_off;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stem_reg  <= '0;
            filt_reg  <= '0;
            dband_reg <= '0;
            dstep_reg <= '0;
        end else begin
            state_reg <= state_next;
            stem_reg  <= stem_next;
            filt_reg  <= filt_next;
            dband_reg <= dband_next;
            dstep_reg <= dstep_next;
        end
    end

    always_comb begin
        case (filt_reg)
            2'd0:    band_off = 2'd0;
            2'd2:    band_off = 2'd1;
            default: band_off = 2'd2;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        stem_next   = stem_reg;
        filt_next   = filt_reg;
        dband_next  = dband_reg;
        dstep_next  = dstep_reg;
        s_ready     = 1'b0;
        cmd.op      = OP_NONE;
        cmd.publish = 1'b0;
        cmd.stem    = stem_reg;
        cmd.filt    = filt_reg;
        cmd.band    = 4'({2'b00, stem_reg} * 4'd3) + {2'b00, band_off};
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                cmd.op     = OP_MIX;
                state_next = ST_HARM;
            end
            ST_HARM: begin
                cmd.op     = OP_HARM;
                state_next = ST_VOC;
            end
            ST_VOC: begin
                cmd.op     = OP_VOC;
                state_next = ST_DRUMS;
            end
            ST_DRUMS: begin
                cmd.op     = OP_DRUMS;
                stem_next  = '0;
                filt_next  = '0;
                state_next = ST_B0;
            end
            ST_B0: begin
                cmd.op     = OP_B0;
                state_next = ST_B1;
            end
            ST_B1: begin
                cmd.op     = OP_B1;
                state_next = ST_A1;
            end
            ST_A1: begin
                cmd.op     = OP_A1;
                state_next = ST_A2;
            end
            ST_A2: begin
                cmd.op     = OP_A2;
                state_next = ST_YY;
            end
            ST_YY: begin
                cmd.op     = OP_YY;
                state_next = ST_EN;
            end
            ST_EN: begin
                cmd.op = OP_EN;
                if (filt_reg == 2'(LAST_FILT)) begin
                    filt_next = '0;
                    if (stem_reg == 2'(LAST_STEM)) begin
                        state_next = ST_CLOSE;
                    end else begin
                        stem_next  = stem_reg + 2'd1;
                        state_next = ST_B0;
                    end
                end else begin
                    filt_next  = filt_reg + 2'd1;
                    state_next = ST_B0;
                end
            end
            ST_CLOSE: begin
                cmd.op = OP_CLOSE;
                if (stat.close && stat.emit) begin
                    dband_next = '0;
                    state_next = ST_WAIT_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT_OUT: begin
                if (!stat.out_busy) begin
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                cmd.op     = OP_DLOAD;
                cmd.band   = dband_reg;
                dstep_next = '0;
                state_next = ST_DSTEP;
            end
            ST_DSTEP: begin
                cmd.op   = OP_DSTEP;
                cmd.band = dband_reg;
                if (dstep_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = ST_DSTORE;
                end else begin
                    dstep_next = dstep_reg + 6'd1;
                end
            end
            ST_DSTORE: begin
                cmd.op   = OP_DSTORE;
                cmd.band = dband_reg;
                if (dband_reg == 4'(NUM_BANDS - 1)) begin
                    state_next = ST_PUBLISH;
                end else begin
                    dband_next = dband_reg + 4'd1;
                    state_next = ST_DLOAD;
                end
            end
            ST_PUBLISH: begin
                cmd.publish = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The quotients may only be written while the output register is free.
    a_div_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DLOAD || state_reg == ST_DSTEP || state_reg == ST_DSTORE ||
         state_reg == ST_PUBLISH) |-> !stat.out_busy)
        else $error("divider runs while a result is still pending");

    a_stem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stem_reg != 2'd3)
        else $error("stem counter out of range");

    a_close_leads_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLOSE && !(stat.close && stat.emit)) |=> state_reg == ST_IDLE)
        else $error("column close without result did not return to idle");

endmodule

>>> hdl/sbpa_dp.sv
// Datapath of the stem band power analyzer: input latches, one shared
// multiplier, biquad delay registers, band accumulators, divider and result register.
// Depends on sbpa_pkg.
module sbpa_dp
    import sbpa_pkg::*;
#(
    parameter int COLUMN_BITS = 20,
    parameter int COEF_BITS   = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    input  logic signed [15:0]      s_mix_left,
    input  logic signed [15:0]      s_mix_right,
    input  logic signed [15:0]      s_harm_left,
    input  logic signed [15:0]      s_harm_right,
    input  logic signed [15:0]      s_voc_left,
    input  logic signed [15:0]      s_voc_right,
    input  logic                    s_stems_present,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [COLUMN_BITS-1:0]  m_column,
    output logic [31:0]             m_drums_low,
    output logic [31:0]             m_drums_mid,
    output logic [31:0]             m_drums_high,
    output logic [31:0]             m_harm_low,
    output logic [31:0]             m_harm_mid,
    output logic [31:0]             m_harm_high,
    output logic [31:0]             m_voc_low,
    output logic [31:0]             m_voc_mid,
    output logic [31:0]             m_voc_high
);

    localparam int CF    = COEF_BITS - 2;
    localparam int MA_W  = (COEF_BITS > 18) ? COEF_BITS : 18;
    localparam int PW    = MA_W + 18;
    localparam int CW    = COLUMN_BITS + 1;
    localparam int CMP_W = (CW > 20) ? CW : 20;
    localparam logic signed [63:0] RND = 64'sd1 <<< (CF - 1);

    function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
        if (v > 64'sd131071) begin
            return 18'sd131071;
        end else if (v < -64'sd131072) begin
            return -18'sd131072;
        end
        return v[17:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    logic signed [15:0]    ml_reg, mr_reg, hl_reg, hr_reg, vl_reg, vr_reg;
    logic                  pres_reg;
    logic signed [17:0]    m_reg, h_reg, v_reg, d_reg, hp_reg, y_reg;
    logic signed [PW-1:0]  prod_reg, b0x_reg, b1x_reg;
    logic signed [31:0]    z1_reg [12];
    logic signed [31:0]    z2_reg [12];
    logic [47:0]           acc_reg [NUM_BANDS];
    logic [15:0]           frames_reg;
    logic [CW-1:0]         col_reg;
    logic [47:0]           q_reg;
    logic [15:0]           rem_reg;
    logic                  out_valid_reg;
    logic [COLUMN_BITS-1:0] out_col_reg;
    logic [31:0]           out_band_reg [NUM_BANDS];

    logic [3:0]                fi;
    logic [4*COEF_BITS+63:0]   coef_pad;
    logic signed [COEF_BITS-1:0] b0, b1, a1, a2;
    logic signed [17:0]        x_sel;
    logic signed [16:0]        msum, hsum, vsum;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [17:0]        mul_b;
    logic signed [PW-1:0]      prod;
    logic signed [17:0]        stem_scaled, y_new;
    logic signed [31:0]        z1_new, z2_new;
    logic [47:0]               energy;
    logic [48:0]               acc_sum;
    logic [15:0]               divisor;
    logic [16:0]               rem_sh, rem_diff;
    logic                      rem_ge;
    logic [15:0]               frames_inc;
    logic                      close, emit;
    logic [CW-1:0]             col_inc;

    assign fi       = {cmd.stem, cmd.filt};
    assign coef_pad = {{(4*COEF_BITS){1'b0}}, cfg.coefs[cmd.filt]};
    assign b0       = coef_pad[0*COEF_BITS +: COEF_BITS];
    assign b1       = coef_pad[1*COEF_BITS +: COEF_BITS];
    assign a1       = coef_pad[2*COEF_BITS +: COEF_BITS];
    assign a2       = coef_pad[3*COEF_BITS +: COEF_BITS];

    assign msum = 17'(ml_reg) + 17'(mr_reg);
    assign hsum = 17'(hl_reg) + 17'(hr_reg);
    assign vsum = 17'(vl_reg) + 17'(vr_reg);

    always_comb begin
        if (cmd.filt == 2'(MID_FILT)) begin
            x_sel = hp_reg;
        end else begin
            case (cmd.stem)
                2'd0:    x_sel = d_reg;
                2'd1:    x_sel = h_reg;
                default: x_sel = v_reg;
            endcase
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MIX: begin
                mul_a = MA_W'($signed({1'b0, cfg.hgain}));
                mul_b = 18'(hsum);
            end
            OP_HARM: begin
                mul_a = MA_W'($signed({1'b0, cfg.vgain}));
                mul_b = 18'(vsum);
            end
            OP_B0: begin
                mul_a = MA_W'(b0);
                mul_b = x_sel;
            end
            OP_B1: begin
                mul_a = MA_W'(b1);
                mul_b = x_sel;
            end
            OP_A1: begin
                mul_a = MA_W'(a1);
                mul_b = y_reg;
            end
            OP_A2: begin
                mul_a = MA_W'(a2);
                mul_b = y_reg;
            end
            OP_YY: begin
                mul_a = MA_W'(y_reg);
                mul_b = y_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod        = PW'(mul_a) * PW'(mul_b);
    assign stem_scaled = pres_reg ? sat18(64'(prod_reg >>> 15)) : 18'sd0;
    assign y_new       = sat18((64'(prod_reg) + 64'(z1_reg[fi]) + RND) >>> CF);
    assign z1_new      = sat32(64'(b1x_reg) - 64'(prod_reg) + 64'(z2_reg[fi]));
    assign z2_new      = sat32(64'(b0x_reg) - 64'(prod_reg));
    assign energy      = 48'(prod_reg >>> 15);
    assign acc_sum     = {1'b0, acc_reg[cmd.band]} + {1'b0, energy};

    assign divisor  = (cfg.spc == 16'd0) ? 16'd1 : cfg.spc;
    assign rem_sh   = {rem_reg, q_reg[47]};
    assign rem_ge   = rem_sh >= {1'b0, divisor};
    assign rem_diff = rem_sh - {1'b0, divisor};

    assign frames_inc = frames_reg + 16'd1;
    assign close      = frames_inc >= cfg.spc;
    assign emit       = CMP_W'(col_reg) < CMP_W'(cfg.limit);
    assign col_inc    = (&col_reg) ? col_reg : col_reg + CW'(1);

    assign stat.close    = close;
    assign stat.emit     = emit;
    assign stat.out_busy = out_valid_reg;

    // Input latches and arithmetic payload.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            ml_reg   <= s_mix_left;
            mr_reg   <= s_mix_right;
            hl_reg   <= s_harm_left;
            hr_reg   <= s_harm_right;
            vl_reg   <= s_voc_left;
            vr_reg   <= s_voc_right;
            pres_reg <= s_stems_present;
        end
        prod_reg <= prod;
        case (cmd.op)
            OP_MIX:   m_reg   <= 18'(msum >>> 1);
            OP_HARM:  h_reg   <= stem_scaled;
            OP_VOC:   v_reg   <= stem_scaled;
            OP_DRUMS: d_reg   <= sat18(64'(m_reg) - 64'(h_reg) - 64'(v_reg));
            OP_B1: begin
                b0x_reg <= prod_reg;
                y_reg   <= y_new;
            end
            OP_A1:    b1x_reg <= prod_reg;
            OP_EN: begin
                if (cmd.filt == 2'(HP_FILT)) begin
                    hp_reg <= y_reg;
                end
            end
            OP_DLOAD: begin
                q_reg   <= acc_reg[cmd.band];
                rem_reg <= '0;
            end
            OP_DSTEP: begin
                q_reg   <= {q_reg[46:0], rem_ge};
                rem_reg <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
            end
            OP_DSTORE: out_band_reg[cmd.band] <= (|q_reg[47:32]) ? 32'hFFFFFFFF : q_reg[31:0];
            default: ;
        endcase
        if (cmd.publish) begin
            out_col_reg <= col_reg[COLUMN_BITS-1:0];
        end
    end

    // Filter, accumulator, column and output-valid state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 12; i++) begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_BANDS; i++) begin
                acc_reg[i] <= '0;
            end
            frames_reg    <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_A2) begin
                z1_reg[fi] <= z1_new;
            end
            if (cmd.op == OP_YY) begin
                z2_reg[fi] <= z2_new;
            end
            if (cmd.op == OP_EN && cmd.filt != 2'(HP_FILT)) begin
                acc_reg[cmd.band] <= acc_sum[48] ? 48'hFFFFFFFFFFFF : acc_sum[47:0];
            end
            if (cmd.op == OP_CLOSE) begin
                frames_reg <= close ? 16'd0 : frames_inc;
                // A suppressed column still clears and advances right here.
                if (close && !emit) begin
                    for (int i = 0; i < NUM_BANDS; i++) begin
                        acc_reg[i] <= '0;
                    end
                    col_reg <= col_inc;
                end
            end
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.publish) begin
                for (int i = 0; i < NUM_BANDS; i++) begin
                    acc_reg[i] <= '0;
                end
                col_reg       <= col_inc;
                out_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_column     = out_col_reg;
    assign m_drums_low  = out_band_reg[0];
    assign m_drums_mid  = out_band_reg[1];
    assign m_drums_high = out_band_reg[2];
    assign m_harm_low   = out_band_reg[3];
    assign m_harm_mid   = out_band_reg[4];
    assign m_harm_high  = out_band_reg[5];
    assign m_voc_low    = out_band_reg[6];
    assign m_voc_mid    = out_band_reg[7];
    assign m_voc_high   = out_band_reg[8];

    a_col_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> col_reg >= $past(col_reg))
        else $error("column counter went backward");

    a_valid_from_publish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(cmd.publish))
        else $error("result raised without a publish command");

endmodule

>>> tb/tb_stem_band_power_analyzer.sv
// Self-checking testbench for stem_band_power_analyzer: a bit-exact predictor
// of the band energies, a randomized sender, a randomly stalling result checker.
// Depends on sbpa_pkg and the stem_band_power_analyzer RTL.
module tb_stem_band_power_analyzer
    import sbpa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int SETTLE_CYCLES   = 1000;

    typedef struct {
        logic signed [15:0] mix_l, mix_r, harm_l, harm_r, voc_l, voc_r;
        logic               present;
    } frame_t;

    typedef struct {
        logic [19:0] column;
        logic [31:0] band [9];
    } column_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [15:0] s_mix_left = '0, s_mix_right = '0, s_harm_left = '0;
    logic signed [15:0] s_harm_right = '0, s_voc_left = '0, s_voc_right = '0;
    logic        s_stems_present = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [19:0] m_column;
    logic [31:0] m_drums_low, m_drums_mid, m_drums_high;
    logic [31:0] m_harm_low, m_harm_mid, m_harm_high;
    logic [31:0] m_voc_low, m_voc_mid, m_voc_high;

    always #1 aclk = ~aclk;

    stem_band_power_analyzer DUT (.*);

    // Predictor state and its copy of the registers.
    logic [63:0] coef_regs [4];
    logic [15:0] frames_per_col, harm_gain, voc_gain;
    logic [19:0] col_limit;
    longint      delays [24];
    longint      band_acc [9];
    int unsigned frame_count;
    longint      col_count;

    column_t     pending_cols [$];
    int          mismatches = 0;
    int          frames_sent = 0;
    int          cols_checked = 0;
    bit          no_idle = 1'b0;
    int          idle_count = 0;

    function automatic longint clamp(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint coef_at(logic [63:0] r, int k);
        return longint'($signed(r[k*16 +: 16]));
    endfunction

    function automatic longint biquad_step(int reg_i, int di, longint x);
        longint b0, b1, a1, a2, y;
        b0 = coef_at(coef_regs[reg_i], 0);
        b1 = coef_at(coef_regs[reg_i], 1);
        a1 = coef_at(coef_regs[reg_i], 2);
        a2 = coef_at(coef_regs[reg_i], 3);
        y = clamp((b0 * x + delays[di] + 8192) >>> 14, 18);
        delays[di]     = clamp(b1 * x - a1 * y + delays[di + 1], 32);
        delays[di + 1] = clamp(b0 * x - a2 * y, 32);
        return y;
    endfunction

    function automatic void add_energy(int idx, longint y);
        longint s;
        s = band_acc[idx] + ((y * y) >>> 15);
        band_acc[idx] = s > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : s;
    endfunction

    function automatic void filter_stem(int s, longint x);
        longint lo, hp, mid, hi;
        lo  = biquad_step(REG_LOW_LP, s * 8, x);
        hp  = biquad_step(REG_LOW_HP, s * 8 + 2, x);
        mid = biquad_step(REG_HIGH_LP, s * 8 + 4, hp);
        hi  = biquad_step(REG_HIGH_HP, s * 8 + 6, x);
        add_energy(s * 3, lo);
        add_energy(s * 3 + 1, mid);
        add_energy(s * 3 + 2, hi);
    endfunction

    function automatic void predict_frame(frame_t f);
        longint  m, h, v, div, q;
        column_t c;
        m = (longint'(f.mix_l) + longint'(f.mix_r)) >>> 1;
        h = 0;
        v = 0;
        if (f.present) begin
            h = clamp(((longint'(f.harm_l) + f.harm_r) * longint'(harm_gain)) >>> 15, 18);
            v = clamp(((longint'(f.voc_l) + f.voc_r) * longint'(voc_gain)) >>> 15, 18);
        end
        filter_stem(0, clamp(m - h - v, 18));
        filter_stem(1, h);
        filter_stem(2, v);
        frame_count = (frame_count + 1) & 16'hFFFF;
        if (frame_count >= frames_per_col) begin
            if (col_count < longint'(col_limit)) begin
                div = frames_per_col == 0 ? 1 : longint'(frames_per_col);
                c.column = col_count[19:0];
                for (int i = 0; i < 9; i++) begin
                    q = band_acc[i] / div;
                    c.band[i] = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
                end
                pending_cols.push_back(c);
            end
            for (int i = 0; i < 9; i++) band_acc[i] = 0;
            frame_count = 0;
            if (col_count < (longint'(1) <<< 21) - 1) col_count++;
        end
    endfunction

    // The block must be idle here; the settle wait covers a column close in flight.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        s_valid <= 1'b0;
        wait (pending_cols.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_SPC:   frames_per_col = val[15:0];
            REG_HGAIN: harm_gain = val[15:0];
            REG_VGAIN: voc_gain = val[15:0];
            REG_LIMIT: col_limit = val[19:0];
            default:   coef_regs[idx[1:0]] = val;
        endcase
    endtask

    task automatic send_frame(frame_t f);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mix_left      <= f.mix_l;
        s_mix_right     <= f.mix_r;
        s_harm_left     <= f.harm_l;
        s_harm_right    <= f.harm_r;
        s_voc_left      <= f.voc_l;
        s_voc_right     <= f.voc_r;
        s_stems_present <= f.present;
        do @(posedge aclk); while (!s_ready);
        predict_frame(f);
        frames_sent++;
    endtask

    function automatic frame_t random_frame();
        frame_t f;
        f.mix_l  = 16'($urandom);
        f.mix_r  = 16'($urandom);
        f.harm_l = 16'($urandom);
        f.harm_r = 16'($urandom);
        f.voc_l  = 16'($urandom);
        f.voc_r  = 16'($urandom);
        f.present = $urandom_range(0, 3) != 0;
        return f;
    endfunction

    function automatic frame_t flat_frame(logic signed [15:0] val, logic present);
        frame_t f;
        f.mix_l = val; f.mix_r = val; f.harm_l = val; f.harm_r = val;
        f.voc_l = val; f.voc_r = val; f.present = present;
        return f;
    endfunction

    function automatic logic [63:0] random_coefs();
        // A stable resonant section half the time, raw bit patterns otherwise.
        if ($urandom_range(0, 1))
            return {16'h399A, 16'h8666, 16'($urandom_range(0, 1023)),
                    16'($urandom_range(0, 1023))};
        return {$urandom, $urandom};
    endfunction

    task automatic test_extremes();
        write_reg(REG_LOW_LP, 64'h0000_0000_0000_4000);
        write_reg(REG_LOW_HP, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_HIGH_LP, 64'h8000_8000_8000_8000);
        write_reg(REG_HIGH_HP, {16'h399A, 16'h8666, 16'h0200, 16'h0100});
        write_reg(REG_SPC, 64'd1);
        write_reg(REG_HGAIN, 64'd65535);
        write_reg(REG_VGAIN, 64'd0);
        write_reg(REG_LIMIT, 64'hF_FFFF);
        send_frame(flat_frame(16'sh7FFF, 1'b1));
        send_frame(flat_frame(-16'sh8000, 1'b1));
        send_frame(flat_frame(16'sh7FFF, 1'b0));
        send_frame(flat_frame(-16'sh8000, 1'b0));
        send_frame(flat_frame(16'sh0000, 1'b1));
        send_frame(flat_frame(-16'sh0001, 1'b1));
        write_reg(REG_VGAIN, 64'd65535);
        write_reg(REG_SPC, 64'd3);
        for (int i = 0; i < 6; i++)
            send_frame(flat_frame(i[0] ? 16'sh7FFF : -16'sh8000, 1'b1));
    endtask

    // Zero frames per column closes a column on every frame.
    task automatic test_zero_frames_per_column();
        write_reg(REG_SPC, 64'd0);
        for (int i = 0; i < 4; i++) send_frame(random_frame());
    endtask

    // Columns at or above the limit are dropped but still advance the counter.
    task automatic test_suppressed_columns();
        write_reg(REG_SPC, 64'd1);
        write_reg(REG_LIMIT, 64'd0);
        for (int i = 0; i < 4; i++) send_frame(random_frame());
        write_reg(REG_LIMIT, 64'(col_count + 2));
        for (int i = 0; i < 4; i++) send_frame(random_frame());
        write_reg(REG_LIMIT, 64'hF_FFFF);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++) begin
            for (int r = 0; r < 4; r++) write_reg(r[2:0], random_coefs());
            write_reg(REG_SPC, 64'($urandom_range(1, 8)));
            write_reg(REG_HGAIN, phase == 0 ? 64'd0 : 64'($urandom_range(0, 65535)));
            write_reg(REG_VGAIN, phase == 1 ? 64'd65535 : 64'($urandom_range(0, 65535)));
            no_idle = phase == 2;
            for (int i = 0; i < 75; i++) send_frame(random_frame());
        end
        no_idle = 1'b0;
    endtask

    // Result checker with a random stall after each beat, none while no_idle is set.
    initial begin
        column_t exp_col;
        logic [31:0] got [9];
        int stall;
        bit bad;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{m_drums_low, m_drums_mid, m_drums_high, m_harm_low, m_harm_mid,
                        m_harm_high, m_voc_low, m_voc_mid, m_voc_high};
                if (pending_cols.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected column beat, column %0d", m_column);
                end else begin
                    exp_col = pending_cols.pop_front();
                    bad = exp_col.column !== m_column;
                    for (int i = 0; i < 9; i++) bad |= exp_col.band[i] !== got[i];
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Column mismatch: expected col %0d %p",
                                     exp_col.column, exp_col.band);
                            $display("                 actual   col %0d %p", m_column, got);
                        end
                    end
                    cols_checked++;
                end
                stall = no_idle ? 0 : $urandom_range(0, 5);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end else if (!m_ready) begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wen || !aresetn) begin
            idle_count <= 0;
        end else if (idle_count >= WATCHDOG_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        for (int i = 0; i < 4; i++) coef_regs[i] = '0;
        frames_per_col = 16'd480;
        harm_gain = 16'd16384;
        voc_gain = 16'd16384;
        col_limit = 20'hF_FFFF;
        for (int i = 0; i < 24; i++) delays[i] = 0;
        for (int i = 0; i < 9; i++) band_acc[i] = 0;
        frame_count = 0;
        col_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_zero_frames_per_column();
        test_suppressed_columns();
        test_random_settings();
        s_valid <= 1'b0;
        wait (pending_cols.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d frames and checked %0d columns over several filter,", frames_sent,
                 cols_checked);
        $display("gain, column length and column limit settings; %0d mismatches.", mismatches);
        if (mismatches == 0 && pending_cols.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> stem_band_power_analyzer.f
hdl/sbpa_pkg.sv
hdl/sbpa_ctrl.sv
hdl/sbpa_dp.sv
hdl/stem_band_power_analyzer.sv
tb/tb_stem_band_power_analyzer.sv
